/* sv/stqr_pkg.sv */
// ----------------------------------------------------------------------------
// stqr_pkg
// Shared constants, payload structs and controller/datapath interface types
// for the sparse table range query unit.
// ----------------------------------------------------------------------------
package stqr_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int MAX_LEVELS   = 11;
  localparam int VALUE_BITS   = 32;
  localparam int RANGE_BITS   = 10;

  localparam int IDX_BITS  = $clog2(MAX_ELEMENTS);
  localparam int CNT_BITS  = IDX_BITS + 1;
  localparam int LVL_BITS  = $clog2(CNT_BITS + 1);
  localparam int ADDR_BITS = LVL_BITS + IDX_BITS;
  localparam int RAM_DEPTH = MAX_ELEMENTS * MAX_LEVELS;
  localparam int SH_BITS   = $clog2(VALUE_BITS);

  localparam int CFG_ADDR_BITS  = 1;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MODE_ADDR = 1'b0;

  typedef enum logic [1:0] {
    MODE_MAX = 2'd0,
    MODE_MIN = 2'd1,
    MODE_SUM = 2'd2,
    MODE_GCD = 2'd3
  } mode_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                          opcode;
    logic signed [VALUE_BITS-1:0]  element_value;
    logic                          last_element;
    logic [RANGE_BITS-1:0]         range_left;
    logic [RANGE_BITS-1:0]         range_right;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  range_result;
    logic                          bad_range;
  } rsp_t;

  typedef enum logic [2:0] {
    RD_BUILD_A,
    RD_BUILD_B,
    RD_FAST_A,
    RD_FAST_B,
    RD_WALK
  } rd_sel_t;

  typedef enum logic [1:0] {
    OUT_SRC_BAD,
    OUT_SRC_CMB,
    OUT_SRC_ACC
  } out_src_t;

  typedef struct packed {
    logic     accept;
    logic     wr_load;
    logic     wr_build;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     cap_a;
    logic     cap_b;
    logic     cmb_start;
    logic     walk_init;
    logic     walk_cap;
    logic     acc_load;
    logic     out_load;
    out_src_t out_src;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic is_last;
    logic multi_level;
    logic bad;
    logic fast;
    logic walk_done;
    logic have;
    logic build_last;
    logic cmb_done;
    logic out_free;
  } dp_status_t;

  // number of significant bits
  function automatic logic [LVL_BITS-1:0] bit_len(input logic [CNT_BITS-1:0] v);
    logic [LVL_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < CNT_BITS; i++) begin
      if (v[i]) n = LVL_BITS'(i + 1);
    end
    return n;
  endfunction

endpackage

/* sv/stqr_ram.sv */
// ----------------------------------------------------------------------------
// stqr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module stqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* sv/stqr_combine.sv */
// ----------------------------------------------------------------------------
// stqr_combine
// Combine unit: max, min and wrapping sum with the result registered in the
// cycle after start, gcd by an iterative binary gcd (one subtract and shift per cycle).
// ----------------------------------------------------------------------------
module stqr_combine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  stqr_pkg::mode_t               mode,
  input  logic [stqr_pkg::VALUE_BITS-1:0] a,
  input  logic [stqr_pkg::VALUE_BITS-1:0] b,
  output logic                          busy,
  output logic                          done,
  output logic [stqr_pkg::VALUE_BITS-1:0] result
);
  import stqr_pkg::*;

  logic [VALUE_BITS-1:0] ga;
  logic [VALUE_BITS-1:0] gb;
  logic [SH_BITS-1:0]    sh;
  logic [VALUE_BITS-1:0] simple;

  always_comb begin
    case (mode)
      MODE_MAX: simple = ($signed(a) >= $signed(b)) ? a : b;
      MODE_MIN: simple = ($signed(a) <= $signed(b)) ? a : b;
      default:  simple = a + b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (mode == MODE_GCD) begin
          busy <= 1'b1;
          ga   <= a;
          gb   <= b;
          sh   <= '0;
        end else begin
          done   <= 1'b1;
          result <= simple;
        end
      end else if (busy) begin
        if (ga == '0) begin
          result <= gb << sh;
          busy   <= 1'b0;
          done   <= 1'b1;
        end else if (gb == '0) begin
          result <= ga << sh;
          busy   <= 1'b0;
          done   <= 1'b1;
        end else if (!ga[0] && !gb[0]) begin
          // common factor of two
          ga <= ga >> 1;
          gb <= gb >> 1;
          sh <= sh + 1'b1;
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga >= gb) begin
          ga <= (ga - gb) >> 1;
        end else begin
          gb <= (gb - ga) >> 1;
        end
      end
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("combine done held for two cycles");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("combine started while busy");
  a_fast_ops: assert property (@(posedge clk) disable iff (rst)
    start && mode != MODE_GCD |=> done)
    else $error("single-cycle combine did not finish");

endmodule

/* sv/stqr_datapath.sv */
// ----------------------------------------------------------------------------
// stqr_datapath
// Level store, counters, address generation, operand and accumulator
// registers, combine unit and output register.
// ----------------------------------------------------------------------------
module stqr_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  stqr_pkg::req_t       req,
  input  stqr_pkg::mode_t      mode,
  input  stqr_pkg::dp_cmd_t    cmd,
  output stqr_pkg::dp_status_t status,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output stqr_pkg::rsp_t       rsp
);
  import stqr_pkg::*;

  req_t                  item;
  logic [CNT_BITS-1:0]   elem_count;
  logic [LVL_BITS-1:0]   lvl_count;
  logic [CNT_BITS-1:0]   load_pos;
  logic [LVL_BITS-1:0]   blvl;
  logic [IDX_BITS-1:0]   bidx;
  logic [CNT_BITS-1:0]   wl;
  logic                  have;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] op_a;
  logic [VALUE_BITS-1:0] op_b;

  logic                  load_room;
  logic [CNT_BITS-1:0]   pos_inc;
  logic [LVL_BITS-1:0]   pos_len;
  logic [LVL_BITS-1:0]   new_lc;
  logic [CNT_BITS-1:0]   ql;
  logic [CNT_BITS-1:0]   qr;
  logic [CNT_BITS-1:0]   qlen;
  logic [LVL_BITS-1:0]   qk;
  logic [CNT_BITS-1:0]   fb_idx;
  logic [CNT_BITS-1:0]   rem;
  logic [LVL_BITS-1:0]   rk;
  logic [LVL_BITS-1:0]   top_lvl;
  logic [LVL_BITS-1:0]   wlv;
  logic [LVL_BITS-1:0]   prev_lvl;
  logic [CNT_BITS-1:0]   half_idx;
  logic [CNT_BITS:0]     bnext;
  logic                  level_end;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic                  cmb_busy;
  logic                  cmb_done;
  logic [VALUE_BITS-1:0] cmb_res;

  assign load_room = load_pos < CNT_BITS'(MAX_ELEMENTS);
  assign pos_inc   = load_pos + CNT_BITS'(load_room);
  assign pos_len   = bit_len(pos_inc);
  assign new_lc    = (pos_len > LVL_BITS'(MAX_LEVELS)) ? LVL_BITS'(MAX_LEVELS) : pos_len;

  assign ql     = CNT_BITS'(item.range_left);
  assign qr     = CNT_BITS'(item.range_right);
  assign qlen   = qr - ql + 1'b1;
  assign qk     = bit_len(qlen) - 1'b1;
  assign fb_idx = qr - (CNT_BITS'(1) << qk) + 1'b1;

  // walk step: largest level that fits the rest, capped at the top level
  assign rem     = qr - wl + 1'b1;
  assign rk      = bit_len(rem) - 1'b1;
  assign top_lvl = lvl_count - 1'b1;
  assign wlv     = (rk < top_lvl) ? rk : top_lvl;

  assign prev_lvl  = blvl - 1'b1;
  assign half_idx  = CNT_BITS'(bidx) + (CNT_BITS'(1) << prev_lvl);
  assign bnext     = (CNT_BITS+1)'(bidx) + 1'b1 + ((CNT_BITS+1)'(1) << blvl);
  assign level_end = bnext > (CNT_BITS+1)'(elem_count);

  always_comb begin
    case (cmd.rd_sel)
      RD_BUILD_A: ram_raddr = {prev_lvl, bidx};
      RD_BUILD_B: ram_raddr = {prev_lvl, half_idx[IDX_BITS-1:0]};
      RD_FAST_A:  ram_raddr = {qk, ql[IDX_BITS-1:0]};
      RD_FAST_B:  ram_raddr = {qk, fb_idx[IDX_BITS-1:0]};
      default:    ram_raddr = {wlv, wl[IDX_BITS-1:0]};
    endcase
  end

  assign ram_we    = (cmd.wr_load && load_room) || cmd.wr_build;
  assign ram_waddr = cmd.wr_build ? {blvl, bidx} : {LVL_BITS'(0), load_pos[IDX_BITS-1:0]};
  assign ram_wdata = cmd.wr_build ? cmb_res : item.element_value;

  stqr_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stqr_combine u_cmb (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.cmb_start),
    .mode   (mode),
    .a      (op_a),
    .b      (op_b),
    .busy   (cmb_busy),
    .done   (cmb_done),
    .result (cmb_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      lvl_count  <= '0;
      load_pos   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.accept) item <= req;

      if (cmd.wr_load) begin
        load_pos <= pos_inc;
        if (item.last_element) begin
          elem_count <= pos_inc;
          lvl_count  <= new_lc;
          load_pos   <= '0;
          blvl       <= LVL_BITS'(1);
          bidx       <= '0;
        end
      end

      if (cmd.wr_build) begin
        if (level_end) begin
          blvl <= blvl + 1'b1;
          bidx <= '0;
        end else begin
          bidx <= bidx + 1'b1;
        end
      end

      if (cmd.cap_a) op_a <= ram_rdata;
      if (cmd.cap_b) op_b <= ram_rdata;

      if (cmd.walk_init) begin
        wl   <= ql;
        have <= 1'b0;
      end
      if (cmd.walk_cap) begin
        op_a <= acc;
        op_b <= ram_rdata;
        wl   <= wl + (CNT_BITS'(1) << wlv);
        if (!have) begin
          acc  <= ram_rdata;
          have <= 1'b1;
        end
      end
      if (cmd.acc_load) acc <= cmb_res;

      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
        rsp.bad_range <= (cmd.out_src == OUT_SRC_BAD);
        case (cmd.out_src)
          OUT_SRC_CMB: rsp.range_result <= cmb_res;
          OUT_SRC_ACC: rsp.range_result <= acc;
          default:     rsp.range_result <= '0;
        endcase
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.is_query    = (item.opcode == OP_QUERY);
    status.is_last     = item.last_element;
    status.multi_level = lvl_count > LVL_BITS'(1);
    status.bad         = (ql > qr) || (qr >= elem_count);
    status.fast        = (mode != MODE_SUM) && (qk < lvl_count);
    status.walk_done   = wl > qr;
    status.have        = have;
    status.build_last  = level_end && ((blvl + 1'b1) == lvl_count);
    status.cmb_done    = cmb_done;
    status.out_free    = !rsp_valid || !rsp_stall;
  end

  a_build_level: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_build |-> blvl != '0 && !cmb_busy)
    else $error("build write to level zero or while combining");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_range |-> rsp.range_result == '0)
    else $error("bad range item with nonzero result");
  a_level_cap: assert property (@(posedge clk) disable iff (rst)
    lvl_count <= LVL_BITS'(MAX_LEVELS) && elem_count <= CNT_BITS'(MAX_ELEMENTS))
    else $error("count registers out of range");

endmodule

/* sv/stqr_ctrl.sv */
// ----------------------------------------------------------------------------
// stqr_ctrl
// Controller: sequences loads, the table build and the two query methods.
// ----------------------------------------------------------------------------
module stqr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  stqr_pkg::dp_status_t status,
  output stqr_pkg::dp_cmd_t    cmd
);
  import stqr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_LOAD, S_LOAD_END,
    S_B_RA, S_B_RB, S_B_RC, S_B_S, S_B_W,
    S_CHECK,
    S_F_RA, S_F_RB, S_F_RC, S_F_S, S_F_W,
    S_W_RD, S_W_CAP, S_W_S, S_W_W, S_W_CHK,
    S_OUT_BAD, S_OUT_CMB, S_OUT_ACC
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_WALK;
    cmd.out_src = OUT_SRC_BAD;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = req_valid;
        if (req_valid) state_next = S_DEC;
      end
      S_DEC:      state_next = status.is_query ? S_CHECK : S_LOAD;
      S_LOAD: begin
        cmd.wr_load = 1'b1;
        state_next  = S_LOAD_END;
      end
      S_LOAD_END: state_next = (status.is_last && status.multi_level) ? S_B_RA : S_IDLE;
      S_B_RA: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BUILD_A;
        state_next = S_B_RB;
      end
      S_B_RB: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BUILD_B;
        cmd.cap_a  = 1'b1;
        state_next = S_B_RC;
      end
      S_B_RC: begin
        cmd.cap_b  = 1'b1;
        state_next = S_B_S;
      end
      S_B_S: begin
        cmd.cmb_start = 1'b1;
        state_next    = S_B_W;
      end
      S_B_W: begin
        if (status.cmb_done) begin
          cmd.wr_build = 1'b1;
          state_next   = status.build_last ? S_IDLE : S_B_RA;
        end
      end
      S_CHECK: begin
        if (status.bad) begin
          state_next = S_OUT_BAD;
        end else if (status.fast) begin
          state_next = S_F_RA;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_W_RD;
        end
      end
      S_F_RA: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FAST_A;
        state_next = S_F_RB;
      end
      S_F_RB: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FAST_B;
        cmd.cap_a  = 1'b1;
        state_next = S_F_RC;
      end
      S_F_RC: begin
        cmd.cap_b  = 1'b1;
        state_next = S_F_S;
      end
      S_F_S: begin
        cmd.cmb_start = 1'b1;
        state_next    = S_F_W;
      end
      S_F_W:      if (status.cmb_done) state_next = S_OUT_CMB;
      S_W_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_WALK;
        state_next = S_W_CAP;
      end
      S_W_CAP: begin
        // first block seeds the accumulator, later ones combine into it
        cmd.walk_cap = 1'b1;
        state_next   = status.have ? S_W_S : S_W_CHK;
      end
      S_W_S: begin
        cmd.cmb_start = 1'b1;
        state_next    = S_W_W;
      end
      S_W_W: begin
        if (status.cmb_done) begin
          cmd.acc_load = 1'b1;
          state_next   = S_W_CHK;
        end
      end
      S_W_CHK:    state_next = status.walk_done ? S_OUT_ACC : S_W_RD;
      S_OUT_BAD: begin
        cmd.out_src = OUT_SRC_BAD;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_OUT_CMB: begin
        cmd.out_src = OUT_SRC_CMB;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_OUT_ACC: begin
        cmd.out_src = OUT_SRC_ACC;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/sparse_table_range_query_unit.sv */
// ----------------------------------------------------------------------------
// sparse_table_range_query_unit
// Sparse table over up to 1024 signed 32-bit elements answering inclusive
// range queries with max, min, wrapping sum or gcd.
// ----------------------------------------------------------------------------
// One item is worked on at a time; req_stall is high until it is finished.
// A load flagged last builds the table from a single-port-read store; gcd
// entries use a binary gcd, one step a cycle. The build of n elements covers
// about n*(log2(n)-1) entries. Sum queries walk the levels, at most 10
// blocks. A finished result sits in the output register, so the next item
// can be taken while it waits. The store needs no clearing after reset. The
// mode register is at address 0.
// ----------------------------------------------------------------------------
module sparse_table_range_query_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  stqr_pkg::req_t                        req,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output stqr_pkg::rsp_t                        rsp,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [stqr_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [stqr_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [stqr_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);
  import stqr_pkg::*;

  mode_t      mode;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MODE_ADDR) ? CFG_DATA_BITS'(mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MAX;
    end else if (psel && penable && pwrite && pready && paddr == REG_MODE_ADDR) begin
      mode <= mode_t'(pwdata[1:0]);
    end
  end

  stqr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  stqr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .mode      (mode),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* sim/tb_sparse_table_range_query_unit.sv */
// ----------------------------------------------------------------------------
// tb_sparse_table_range_query_unit
// Self-checking test of the sparse table range query unit: loads arrays,
// builds the table under every combine mode, issues range queries and checks
// every response against an in-bench predictor of the table and its queries.
// ----------------------------------------------------------------------------
module tb_sparse_table_range_query_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import stqr_pkg::*;

  localparam int CYCLE_LIMIT = 2500000;
  localparam int ITEM_TARGET = 1600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  sparse_table_range_query_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [VALUE_BITS-1:0] levels [MAX_LEVELS][MAX_ELEMENTS];
  int unsigned elem_cnt, lvl_cnt, load_pos;
  mode_t cur_mode;

  rsp_t pending_results[$];
  int errors, mismatches, results_seen, items_sent, queries_sent;
  int unsigned cycles;
  bit quiet;            // no idling on either side
  int hold_request;     // long receiver hold-off asked by a test
  int hold_left;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left <= hold_request;
      hold_request = 0;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 20);
    end
  end

  // response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected result %0d bad=%0b", rsp.range_result, rsp.bad_range);
      end else begin
        want = pending_results.pop_front();
        if (want.range_result !== rsp.range_result || want.bad_range !== rsp.bad_range) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected %0d bad=%0b, got %0d bad=%0b",
                     want.range_result, want.bad_range, rsp.range_result, rsp.bad_range);
        end
      end
    end
  end

  function automatic int unsigned bits_needed(int unsigned v);
    int unsigned n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  function automatic logic [VALUE_BITS-1:0] merge(mode_t m, logic [VALUE_BITS-1:0] a,
                                                  logic [VALUE_BITS-1:0] b);
    logic [VALUE_BITS-1:0] x, y, t;
    case (m)
      MODE_MAX: return ($signed(a) >= $signed(b)) ? a : b;
      MODE_MIN: return ($signed(a) <= $signed(b)) ? a : b;
      MODE_SUM: return a + b;
      default: begin
        x = (a < b) ? b : a;
        y = (a < b) ? a : b;
        while (y != 0) begin
          t = y;
          y = x % y;
          x = t;
        end
        return x;
      end
    endcase
  endfunction

  function automatic logic [VALUE_BITS-1:0] range_answer(int unsigned l, int unsigned r);
    int unsigned k, lv;
    logic [VALUE_BITS-1:0] acc;
    bit have;
    k = bits_needed(r - l + 1) - 1;
    if (cur_mode != MODE_SUM && k < lvl_cnt)
      return merge(cur_mode, levels[k][l], levels[k][r - (1 << k) + 1]);
    have = 0;
    acc = '0;
    while (l <= r) begin
      lv = (lvl_cnt > 0) ? lvl_cnt - 1 : 0;
      while (lv > 0 && (1 << lv) > r - l + 1) lv--;
      acc = have ? merge(cur_mode, acc, levels[lv][l]) : levels[lv][l];
      have = 1;
      l += 1 << lv;
    end
    return acc;
  endfunction

  // update the predicted table, or queue the expected result, for one accepted item
  task automatic track_item(req_t it);
    rsp_t res;
    if (it.opcode == OP_LOAD) begin
      if (load_pos < MAX_ELEMENTS) begin
        levels[0][load_pos] = it.element_value;
        load_pos++;
      end
      if (it.last_element) begin
        elem_cnt = load_pos;
        lvl_cnt = bits_needed(elem_cnt);
        if (lvl_cnt > MAX_LEVELS) lvl_cnt = MAX_LEVELS;
        load_pos = 0;
        for (int j = 1; j < lvl_cnt; j++)
          for (int i = 0; i + (1 << j) <= elem_cnt; i++)
            levels[j][i] = merge(cur_mode, levels[j-1][i], levels[j-1][i + (1 << (j-1))]);
      end
    end else begin
      queries_sent++;
      if (it.range_left > it.range_right || it.range_right >= elem_cnt) begin
        res.range_result = '0;
        res.bad_range = 1'b1;
      end else begin
        res.range_result = range_answer(it.range_left, it.range_right);
        res.bad_range = 1'b0;
      end
      pending_results.push_back(res);
    end
  endtask

  task automatic send_item(req_t it);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
    track_item(it);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3) - 1;
      3: return $urandom_range(0, 60) * (1 << $urandom_range(0, 20));
      4: return $urandom_range(0, 60) * 36;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_one(logic [VALUE_BITS-1:0] v, bit last);
    req_t it;
    it.opcode = OP_LOAD;
    it.element_value = v;
    it.last_element = last;
    it.range_left = RANGE_BITS'($urandom);
    it.range_right = RANGE_BITS'($urandom);
    send_item(it);
  endtask

  task automatic query_one(int unsigned l, int unsigned r);
    req_t it;
    it.opcode = OP_QUERY;
    it.element_value = $urandom;
    it.last_element = 1'($urandom);
    it.range_left = RANGE_BITS'(l);
    it.range_right = RANGE_BITS'(r);
    send_item(it);
  endtask

  task automatic load_array(int n);
    for (int i = 0; i < n; i++) load_one(pick_value(), i == n - 1);
  endtask

  // block idle: every result in and the unit no longer busy
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_MODE_ADDR;
    pwdata <= CFG_DATA_BITS'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_mode = m;
  endtask

  task automatic test_before_build();
    query_one(0, 0);
    query_one(1023, 1023);
    query_one(5, 2);
  endtask

  task automatic test_directed();
    write_mode(MODE_MAX);
    load_one(32'h8000_0000, 0);
    load_one(32'h7fff_ffff, 0);
    load_one(32'hffff_ffff, 0);
    load_one(32'h0, 0);
    load_one(32'h1, 1);
    query_one(0, 4);
    query_one(2, 3);
    query_one(3, 1);
    query_one(0, 5);
    // levels were built with max, queries now combine with sum
    write_mode(MODE_SUM);
    query_one(0, 4);
    query_one(0, 1);
    write_mode(MODE_MIN);
    query_one(1, 4);
    write_mode(MODE_GCD);
    load_one(32'd48, 0);
    load_one(32'hffff_ffd0, 0);
    load_one(32'd0, 1);
    query_one(0, 2);
    query_one(0, 0);
    query_one(2, 2);
    // loads without last overwrite level 0 in place
    load_one(32'd18, 0);
    query_one(0, 1);
    query_one(0, 2);
  endtask

  task automatic test_capacity();
    write_mode(MODE_MIN);
    for (int i = 0; i < MAX_ELEMENTS + 2; i++)
      load_one(pick_value(), i == MAX_ELEMENTS + 1);
    query_one(0, 1023);
    query_one(1023, 1023);
    query_one(0, 0);
    for (int i = 0; i < 12; i++) begin
      int unsigned l;
      l = $urandom_range(0, 1023);
      query_one(l, $urandom_range(l, 1023));
    end
    write_mode(MODE_SUM);
    query_one(0, 1023);
    query_one(1, 1022);
  endtask

  task automatic test_random();
    int phase, n, nq;
    int unsigned l;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      write_mode(mode_t'(phase % 4));
      quiet = (phase % 7 == 3);
      n = ($urandom_range(0, 9) == 0 && phase % 4 != 3) ? $urandom_range(41, 160)
                                                       : $urandom_range(1, 40);
      load_array(n);
      if (phase % 9 == 4) hold_request = 400;
      nq = $urandom_range(6, 20);
      for (int q = 0; q < nq; q++) begin
        case ($urandom_range(0, 19))
          0: query_one($urandom_range(0, 1023), $urandom_range(0, 1023));
          1: load_one(pick_value(), 0);
          default: begin
            l = $urandom_range(0, n - 1);
            query_one(l, $urandom_range(l, n - 1));
          end
        endcase
      end
      // a query at the end keeps the unit idle once results are in
      query_one(0, n - 1);
      quiet = 0;
      phase++;
    end
  endtask

  initial begin
    elem_cnt = 0;
    lvl_cnt = 0;
    load_pos = 0;
    cur_mode = MODE_MAX;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_build();
    test_directed();
    test_capacity();
    test_random();
    settle();
    repeat (50) @(posedge clk);
    errors += pending_results.size();
    $display("sent %0d items (%0d queries), checked %0d results over all four modes",
             items_sent, queries_sent, results_seen);
    $display("covered full capacity, overflow loads, bad ranges and mode change after build");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
sv/stqr_pkg.sv
sv/stqr_ram.sv
sv/stqr_combine.sv
sv/stqr_datapath.sv
sv/stqr_ctrl.sv
sv/sparse_table_range_query_unit.sv
sim/tb_sparse_table_range_query_unit.sv
